@@ rtl/pgbs_pkg.sv @@
// pgbs_pkg: constants, codes and types shared by the periodic grid score unit
// used by the channel interfaces, the controller, the datapath and the top level
package pgbs_pkg;

   localparam int ANGLE_STEPS = 180;
   localparam int GRID_SIZE   = ANGLE_STEPS * ANGLE_STEPS;
   localparam int ADDR_W      = $clog2(GRID_SIZE);
   localparam int IDX_W       = $clog2(ANGLE_STEPS);
   localparam int DEG         = 256;

   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int ENERGY_W = 33;
   localparam int ANGLE_W  = 18;
   localparam int SCALE_W  = 16;
   localparam int FRAC_W   = 8;

   // weight of one axis is 0..512, the full weight of a corner up to 512*512
   localparam int T_W        = 9;
   localparam int W_W        = 2 * T_W + 1;
   localparam int PROD_W     = VALUE_W + W_W;
   localparam int SCORE_SHIFT = 2 * T_W;

   localparam logic signed [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(180 * DEG);
   localparam logic signed [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360 * DEG);
   localparam logic signed [IDX_W:0]     LOW_EDGE  = (IDX_W+1)'(-180);
   localparam logic signed [IDX_W+1:0]   IDX_BIAS  = (IDX_W+2)'(179);
   localparam logic [IDX_W-1:0]          LAST_IDX  = IDX_W'(ANGLE_STEPS - 1);
   localparam logic [T_W:0]              TWO_DEG   = (T_W+1)'(2 * DEG);
   localparam logic [ADDR_W-1:0]         GRID_FULL = ADDR_W'(GRID_SIZE);
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0]  ROUND_INIT = PROD_W'(2**(SCORE_SHIFT-1));
   localparam logic [SCALE_W-1:0]        SCALE_RESET = SCALE_W'(256);

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [2:0] LAST_STEP = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       capture;
      logic       setup;
      logic       rd;
      logic       mul;
      logic       acc;
      logic [1:0] corner;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic table_full;
   } status_type;

endpackage

@@ rtl/pgbs_chan_if.sv @@
// pgbs_req_if and pgbs_rsp_if: valid/ready channels of the periodic grid score unit
// depends on pgbs_pkg for field widths
interface pgbs_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [pgbs_pkg::MODE_W-1:0]               mode;
   logic signed [pgbs_pkg::VALUE_W-1:0]       table_value;
   logic signed [pgbs_pkg::ANGLE_W-1:0]       phi_angle;
   logic signed [pgbs_pkg::ANGLE_W-1:0]       psi_angle;

   modport source (output valid, mode, table_value, phi_angle, psi_angle, input ready);
   modport sink (input valid, mode, table_value, phi_angle, psi_angle, output ready);
endinterface

interface pgbs_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [pgbs_pkg::VALUE_W-1:0]       score;
   logic signed [pgbs_pkg::ENERGY_W-1:0]      energy;
   logic                                      table_ready;

   modport source (output valid, score, energy, table_ready, input ready);
   modport sink (input valid, score, energy, table_ready, output ready);
endinterface

@@ rtl/pgbs_ctrl.sv @@
// pgbs_ctrl: state machine that sequences loads, clears and the four-corner query
// depends on pgbs_pkg; drives the datapath through pgbs_pkg::cmd_type
module pgbs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [pgbs_pkg::MODE_W-1:0] req_mode,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  pgbs_pkg::status_type        status,
   output pgbs_pkg::cmd_type           cmd
);

   localparam logic [2:0] LAST_STEP_L = pgbs_pkg::LAST_STEP;

   pgbs_pkg::state_type state_ff, state_in;
   logic [2:0]          step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgbs_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      accept       = 1'b0;
      case (state_ff)
         pgbs_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            accept      = req_valid;
            cmd.load    = accept && (req_mode == pgbs_pkg::MODE_LOAD);
            cmd.clear   = accept && (req_mode == pgbs_pkg::MODE_CLEAR);
            cmd.capture = accept && (req_mode == pgbs_pkg::MODE_QUERY);
            if (cmd.capture) begin
               // an item on an incomplete table skips straight to the result
               state_in = status.table_full ? pgbs_pkg::ST_SETUP : pgbs_pkg::ST_FINISH;
            end
         end
         pgbs_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            step_in   = '0;
            state_in  = pgbs_pkg::ST_RUN;
         end
         pgbs_pkg::ST_RUN: begin
            // read, multiply and accumulate overlap as a pipeline through rd_ff and w_ff, then prod_ff, then acc_ff
            cmd.rd     = !step_ff[2];
            cmd.mul    = (step_ff != 3'd0) && (step_ff != LAST_STEP_L);
            cmd.acc    = (step_ff >= 3'd2);
            cmd.corner = step_ff[1:0];
            step_in    = step_ff + 3'd1;
            if (step_ff == LAST_STEP_L) begin
               state_in = pgbs_pkg::ST_FINISH;
            end
         end
         pgbs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pgbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pgbs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/pgbs_dp.sv @@
// pgbs_dp: grid memory, load scaling, running maximum and the interpolation datapath
// depends on pgbs_pkg; steered by pgbs_ctrl through pgbs_pkg::cmd_type
module pgbs_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [pgbs_pkg::SCALE_W-1:0]          csr_wdata,
   input  pgbs_pkg::cmd_type                     cmd,
   output pgbs_pkg::status_type                  status,
   input  logic signed [pgbs_pkg::VALUE_W-1:0]   table_value,
   input  logic signed [pgbs_pkg::ANGLE_W-1:0]   phi_angle,
   input  logic signed [pgbs_pkg::ANGLE_W-1:0]   psi_angle,
   output logic signed [pgbs_pkg::VALUE_W-1:0]   score,
   output logic signed [pgbs_pkg::ENERGY_W-1:0]  energy,
   output logic                                  table_ready
);

   typedef struct packed {
      logic [pgbs_pkg::IDX_W-1:0] lo;
      logic [pgbs_pkg::IDX_W-1:0] hi;
      logic [pgbs_pkg::T_W-1:0]   t;
   } split_type;

   // wrap once into -180..180 degrees, then find the odd grid points around the angle
   function automatic split_type split_angle(input logic signed [pgbs_pkg::ANGLE_W-1:0] a);
      logic signed [pgbs_pkg::ANGLE_W-1:0] w;
      logic signed [pgbs_pkg::IDX_W:0]     f;
      logic signed [pgbs_pkg::IDX_W+1:0]   s;
      split_type                           r;
      w = a;
      if (a > pgbs_pkg::HALF_TURN) begin
         w = a - pgbs_pkg::FULL_TURN;
      end else if (a < -pgbs_pkg::HALF_TURN) begin
         w = a + pgbs_pkg::FULL_TURN;
      end
      f = w[pgbs_pkg::FRAC_W +: (pgbs_pkg::IDX_W+1)];
      s = {f[pgbs_pkg::IDX_W], f} + pgbs_pkg::IDX_BIAS;
      // -180 degrees has its lower point at -181, which wraps to the last row
      r.lo = (f == pgbs_pkg::LOW_EDGE) ? pgbs_pkg::LAST_IDX : s[pgbs_pkg::IDX_W:1];
      r.hi = (r.lo == pgbs_pkg::LAST_IDX) ? '0 : r.lo + 1'b1;
      r.t  = {~f[0], w[pgbs_pkg::FRAC_W-1:0]};
      return r;
   endfunction

   logic signed [pgbs_pkg::VALUE_W-1:0] mem [pgbs_pkg::GRID_SIZE];

   logic [pgbs_pkg::SCALE_W-1:0]         scale_ff;
   logic [pgbs_pkg::ADDR_W-1:0]          ptr_ff;
   logic signed [pgbs_pkg::VALUE_W-1:0]  max_ff;
   logic signed [pgbs_pkg::VALUE_W-1:0]  rd_ff;
   logic signed [pgbs_pkg::ANGLE_W-1:0]  phi_ff, psi_ff;
   logic                                 full_q_ff;
   logic [pgbs_pkg::IDX_W-1:0]           i1_ff, i2_ff, j1_ff, j2_ff;
   logic [pgbs_pkg::T_W-1:0]             tp_ff, ts_ff;
   logic [pgbs_pkg::W_W-1:0]             w_ff, w_in;
   logic signed [pgbs_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [pgbs_pkg::PROD_W-1:0]   acc_ff;
   logic signed [pgbs_pkg::VALUE_W-1:0]  score_ff, score_in;
   logic signed [pgbs_pkg::ENERGY_W-1:0] energy_ff, energy_in;
   logic                                 ready_ff;

   logic                                 full;
   logic                                 write_en;
   logic [pgbs_pkg::VALUE_W+pgbs_pkg::SCALE_W-1:0] scale_prod;
   logic [pgbs_pkg::VALUE_W+pgbs_pkg::SCALE_W-pgbs_pkg::FRAC_W-1:0] scaled;
   logic signed [pgbs_pkg::VALUE_W-1:0]  stored;
   split_type                            phi_sp, psi_sp;
   logic [pgbs_pkg::IDX_W-1:0]           row, col;
   logic [pgbs_pkg::ADDR_W-1:0]          rd_addr, addr;
   logic [pgbs_pkg::T_W:0]               wa, wb;
   logic [2*pgbs_pkg::T_W+1:0]           w_full;
   logic signed [pgbs_pkg::PROD_W:0]     prod_full;

   assign full              = (ptr_ff == pgbs_pkg::GRID_FULL);
   assign status.table_full = full;
   assign write_en          = cmd.load && !full;

   // positive entries are scaled by the Q8.8 factor and saturate
   assign scale_prod = $unsigned(table_value) * scale_ff;
   assign scaled     = scale_prod[pgbs_pkg::FRAC_W +: $bits(scaled)];
   always_comb begin
      stored = table_value;
      if (table_value > 0) begin
         stored = (|scaled[$bits(scaled)-1:pgbs_pkg::VALUE_W-1]) ? pgbs_pkg::VALUE_MAX
                                                               : scaled[pgbs_pkg::VALUE_W-1:0];
      end
   end

   assign phi_sp = split_angle(phi_ff);
   assign psi_sp = split_angle(psi_ff);

   // corner bit 0 picks the upper first angle, bit 1 the upper second angle
   assign row     = cmd.corner[0] ? i2_ff : i1_ff;
   assign col     = cmd.corner[1] ? j2_ff : j1_ff;
   assign rd_addr = pgbs_pkg::ADDR_W'(row * pgbs_pkg::ANGLE_STEPS) + pgbs_pkg::ADDR_W'(col);
   assign addr    = cmd.load ? ptr_ff : rd_addr;

   assign wa     = cmd.corner[0] ? {1'b0, tp_ff} : pgbs_pkg::TWO_DEG - {1'b0, tp_ff};
   assign wb     = cmd.corner[1] ? {1'b0, ts_ff} : pgbs_pkg::TWO_DEG - {1'b0, ts_ff};
   assign w_full = wa * wb;
   assign w_in   = w_full[pgbs_pkg::W_W-1:0];

   assign prod_full = rd_ff * $signed({1'b0, w_ff});
   assign prod_in   = prod_full[pgbs_pkg::PROD_W-1:0];

   // accumulator starts at half an output step, so this is round half up
   assign score_in  = full_q_ff ? acc_ff[pgbs_pkg::SCORE_SHIFT +: pgbs_pkg::VALUE_W] : '0;
   assign energy_in = full_q_ff ? {max_ff[pgbs_pkg::VALUE_W-1], max_ff}
                                  - {score_in[pgbs_pkg::VALUE_W-1], score_in} : '0;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= stored;
      end
      if (cmd.rd) begin
         rd_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= pgbs_pkg::SCALE_RESET;
         ptr_ff   <= '0;
         max_ff   <= '0;
      end else begin
         if (csr_we) begin
            scale_ff <= csr_wdata;
         end
         if (cmd.clear) begin
            ptr_ff <= '0;
            max_ff <= '0;
         end else if (write_en) begin
            ptr_ff <= ptr_ff + 1'b1;
            if (table_value > max_ff) begin
               max_ff <= table_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         phi_ff    <= phi_angle;
         psi_ff    <= psi_angle;
         full_q_ff <= full;
      end
      if (cmd.setup) begin
         i1_ff  <= phi_sp.lo;
         i2_ff  <= phi_sp.hi;
         tp_ff  <= phi_sp.t;
         j1_ff  <= psi_sp.lo;
         j2_ff  <= psi_sp.hi;
         ts_ff  <= psi_sp.t;
         acc_ff <= pgbs_pkg::ROUND_INIT;
      end else if (cmd.acc) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.rd) begin
         w_ff <= w_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.finish) begin
         score_ff  <= score_in;
         energy_ff <= energy_in;
         ready_ff  <= full_q_ff;
      end
   end

   assign score       = score_ff;
   assign energy      = energy_ff;
   assign table_ready = ready_ff;

endmodule

@@ rtl/periodic_grid_bilinear_score_unit.sv @@
// periodic_grid_bilinear_score_unit: loads a 180x180 periodic table, answers angle queries
// load and clear items leave the unit idle, so they may follow back to back
// a query on a full table runs setup, four reads of the single-port grid memory feeding
// a multiply-accumulate pipe, then finish; an incomplete table skips to finish with zeros
// reset zeroes pointer and running maximum and sets scale to 256; the grid memory is not cleared
module periodic_grid_bilinear_score_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [pgbs_pkg::SCALE_W-1:0] csr_wdata,
   pgbs_req_if.sink                     req_chan,
   pgbs_rsp_if.source                   rsp_chan
);

   pgbs_pkg::cmd_type    cmd;
   pgbs_pkg::status_type status;

   pgbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pgbs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .table_value (req_chan.table_value),
      .phi_angle   (req_chan.phi_angle),
      .psi_angle   (req_chan.psi_angle),
      .score       (rsp_chan.score),
      .energy      (rsp_chan.energy),
      .table_ready (rsp_chan.table_ready)
   );

   // a query holds off the next item until its result is in the output register
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.mode == pgbs_pkg::MODE_QUERY)
      |=> !req_chan.ready)
      else $error("item accepted while a query is in flight");

   // the output register is only overwritten once its item is gone
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("pending result overwritten");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.table_ready) |-> (rsp_chan.score == '0 && rsp_chan.energy == '0))
      else $error("nonzero result on an incomplete table");

endmodule
